[rtl/cross_stencil_bright_spot_counter_unit_assert.svh]
// Assertion macros shared by the cross stencil counter RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef CROSS_STENCIL_BRIGHT_SPOT_COUNTER_UNIT_ASSERT_SVH
`define CROSS_STENCIL_BRIGHT_SPOT_COUNTER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSBS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/csbs_pkg.sv]
// Shared types and constants for the cross stencil bright spot counter.
// No dependencies; imported by every module of the block.
package csbs_pkg;

	localparam int PIX_W      = 16;
	localparam int SIZE_W     = 11;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int SUM_W      = 19;
	localparam int COUNT_W    = 20;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AVG_THRESHOLD = 2'd2;

	localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 16'd6;
	localparam logic [COUNT_W-1:0]    COUNT_MAX       = {COUNT_W{1'b1}};

	// Where the current pixel sits in the frame.
	typedef struct packed {
		logic interior;   // the pixel above is a stencil centre
		logic row_end;
		logic frame_end;
	} pos_t;

endpackage

[rtl/csbs_raster_ctr.sv]
// Raster position tracker: column and row of the next pixel, with wrap at frame size.
// Depends on csbs_pkg for pos_t.
module csbs_raster_ctr
	import csbs_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            restart,
	input  logic                            advance,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]  width,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0] height,
	output logic [$clog2(MAX_WIDTH)-1:0]    col,
	output pos_t                            pos
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          col_inner;
	logic          row_last;

	assign col_inner = (WW'(col_q) + WW'(1)) < width;
	assign row_last  = (HW'(row_q) + HW'(1)) >= height;

	assign col = col_q;

	always_comb begin
		pos.interior  = (row_q >= RW'(2)) && (col_q != '0) && col_inner;
		pos.row_end   = !col_inner;
		pos.frame_end = !col_inner && row_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (pos.row_end) begin
				col_q <= '0;
				row_q <= pos.frame_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

[rtl/csbs_line_store.sv]
// Two line memories holding the previous two rows, with registered reads.
// Depends on csbs_pkg for the pixel width.
module csbs_line_store
	import csbs_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
	input  logic [PIX_W-1:0]             wr_pixel,
	output logic [PIX_W-1:0]             up,
	output logic [PIX_W-1:0]             centre,
	output logic [PIX_W-1:0]             right,
	output logic [PIX_W-1:0]             left
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [PIX_W-1:0] above_mem [MAX_WIDTH];
	logic [PIX_W-1:0] two_above_mem [MAX_WIDTH];
	logic [PIX_W-1:0] left_q;
	logic [CW-1:0]    next_col;

	assign next_col = (rd_col == CW'(MAX_WIDTH - 1)) ? '0 : rd_col + CW'(1);
	assign left     = left_q;

	// The row-above value read for a column drops into the two-above row when
	// that column is written back; it also becomes the left tap of the next item.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			up     <= two_above_mem[rd_col];
			centre <= above_mem[rd_col];
			right  <= above_mem[next_col];
		end
		if (wr_en) begin
			above_mem[wr_col]     <= wr_pixel;
			two_above_mem[wr_col] <= centre;
			left_q                <= centre;
		end
	end

endmodule

[rtl/csbs_cross_cmp.sv]
// Five-point cross sum and comparison against the precomputed bright limit.
// Depends on csbs_pkg for widths.
module csbs_cross_cmp
	import csbs_pkg::*;
(
	input  logic [PIX_W-1:0] pixel,
	input  logic [PIX_W-1:0] up,
	input  logic [PIX_W-1:0] centre,
	input  logic [PIX_W-1:0] left,
	input  logic [PIX_W-1:0] right,
	input  logic [SUM_W-1:0] limit,
	output logic             bright
);

	logic [SUM_W-1:0] sum;

	assign sum    = (SUM_W'(up) + SUM_W'(centre)) + (SUM_W'(left) + SUM_W'(right))
		+ SUM_W'(pixel);
	assign bright = sum >= limit;

endmodule

[rtl/cross_stencil_bright_spot_counter_unit.sv]
// Cross stencil bright spot counter, top level.
// Takes pixels in raster order on the in channel; for every interior pixel the
// sum of it and its four direct neighbours is compared with 5*(threshold+1).
// The count of bright centres leaves on the out channel once per frame, with
// the last pixel of the frame; the count then restarts for the next frame.
// The last pixel of a frame is registered in stage 1 and, as it leaves stage 1,
// sets the registered out_valid. Throughput: one pixel per cycle while no
// frame end waits on an untaken result; a pixel is judged in the cycle after
// it is accepted, using registered reads of the two line memories.
// Reset clears position, count and out_valid; width 8, height 6, threshold 6.
// Line memories are not cleared: no stencil reads a column that was not written.
// A write to any of the three defined registers restarts the frame at column 0, row 0, count 0.
// If the receiver stalls, the result holds and the next pixel is still taken;
// only a second frame end waits until the held result is taken.
// Depends on csbs_pkg, csbs_raster_ctr, csbs_line_store, csbs_cross_cmp.
`include "cross_stencil_bright_spot_counter_unit_assert.svh"

module cross_stencil_bright_spot_counter_unit
	import csbs_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      pixel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COUNT_W-1:0]    bright_count
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int WCMPW = (WW > SIZE_W) ? WW : SIZE_W;
	localparam int HCMPW = (HW > SIZE_W) ? HW : SIZE_W;
	localparam int W_RST = (8 > MAX_WIDTH) ? MAX_WIDTH : 8;
	localparam int H_RST = (6 > MAX_HEIGHT) ? MAX_HEIGHT : 6;

	logic [WW-1:0]      width_q;
	logic [HW-1:0]      height_q;
	logic [SUM_W-1:0]   limit_q;
	logic [WCMPW-1:0]   cfg_w_ext;
	logic [HCMPW-1:0]   cfg_h_ext;
	logic [WW-1:0]      cfg_w_clamped;
	logic [HW-1:0]      cfg_h_clamped;
	logic               cfg_hit;

	logic               in_fire;
	logic [CW-1:0]      col;
	pos_t               pos;

	logic               valid_s1;
	logic [PIX_W-1:0]   pixel_s1;
	logic [CW-1:0]      col_s1;
	pos_t               pos_s1;
	logic               adv_s1;

	logic [PIX_W-1:0]   up_s1;
	logic [PIX_W-1:0]   centre_s1;
	logic [PIX_W-1:0]   right_s1;
	logic [PIX_W-1:0]   left_s1;
	logic               bright_s1;

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;
	logic               out_valid_q;
	logic [COUNT_W-1:0] bright_count_q;

	// Configuration: sizes are stored already clamped, threshold as its limit.
	assign cfg_hit = cfg_write && (cfg_index == REG_FRAME_WIDTH
		|| cfg_index == REG_FRAME_HEIGHT || cfg_index == REG_AVG_THRESHOLD);

	assign cfg_w_ext = WCMPW'(cfg_data[SIZE_W-1:0]);
	assign cfg_h_ext = HCMPW'(cfg_data[SIZE_W-1:0]);

	always_comb begin
		if (cfg_w_ext == '0) begin
			cfg_w_clamped = WW'(1);
		end else if (cfg_w_ext > WCMPW'(MAX_WIDTH)) begin
			cfg_w_clamped = WW'(MAX_WIDTH);
		end else begin
			cfg_w_clamped = WW'(cfg_w_ext);
		end
		if (cfg_h_ext == '0) begin
			cfg_h_clamped = HW'(1);
		end else if (cfg_h_ext > HCMPW'(MAX_HEIGHT)) begin
			cfg_h_clamped = HW'(MAX_HEIGHT);
		end else begin
			cfg_h_clamped = HW'(cfg_h_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(W_RST);
			height_q <= HW'(H_RST);
			limit_q  <= (SUM_W'(THRESHOLD_RESET) << 2) + SUM_W'(THRESHOLD_RESET) + SUM_W'(5);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:   width_q  <= cfg_w_clamped;
				REG_FRAME_HEIGHT:  height_q <= cfg_h_clamped;
				REG_AVG_THRESHOLD: limit_q  <= (SUM_W'(cfg_data) << 2) + SUM_W'(cfg_data)
					+ SUM_W'(5);
				default: ;
			endcase
		end
	end

	// Stage 1 holds the accepted pixel while the memories return its neighbours.
	// Only a frame-end item can be held back, by an untaken result.
	assign adv_s1   = valid_s1 && (!pos_s1.frame_end || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_fire  = in_valid && in_ready;

	csbs_raster_ctr #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_raster (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_hit),
		.advance (in_fire),
		.width   (width_q),
		.height  (height_q),
		.col     (col),
		.pos     (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pixel_s1 <= pixel;
			col_s1   <= col;
			pos_s1   <= pos;
		end
	end

	csbs_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_lines (
		.clk      (clk),
		.rd_en    (in_fire),
		.rd_col   (col),
		.wr_en    (adv_s1),
		.wr_col   (col_s1),
		.wr_pixel (pixel_s1),
		.up       (up_s1),
		.centre   (centre_s1),
		.right    (right_s1),
		.left     (left_s1)
	);

	csbs_cross_cmp u_cmp (
		.pixel  (pixel_s1),
		.up     (up_s1),
		.centre (centre_s1),
		.left   (left_s1),
		.right  (right_s1),
		.limit  (limit_q),
		.bright (bright_s1)
	);

	assign count_next = count_q + COUNT_W'(pos_s1.interior && bright_s1
		&& (count_q != COUNT_MAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_hit) begin
			count_q <= '0;
		end else if (adv_s1) begin
			count_q <= pos_s1.frame_end ? '0 : count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && pos_s1.frame_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pos_s1.frame_end) begin
			bright_count_q <= count_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign bright_count = bright_count_q;

	`CSBS_ASSERT_NEXT(a_frame_end_loads_out, adv_s1 && pos_s1.frame_end, out_valid_q,
		"frame end did not produce a result")
	`CSBS_ASSERT_SAME(a_no_overwrite, valid_s1 && pos_s1.frame_end && out_valid_q && !out_ready,
		!in_ready && !adv_s1, "pending result could be overwritten")
	`CSBS_ASSERT_NEXT(a_count_restarts, adv_s1 && pos_s1.frame_end, count_q == '0,
		"count not cleared after frame end")

endmodule

[tb/csbs_count_checker.sv]
`timescale 1ns / 100ps
// Checker for the cross stencil bright spot counter: mirrors the register writes
// and pixel stream, predicts each frame's bright count and compares the results.
// Depends on csbs_pkg only; it watches the block's ports and drives nothing.
module csbs_count_checker
	import csbs_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [PIX_W-1:0]      pixel,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [COUNT_W-1:0]    bright_count,
	output int                    errors,
	output int                    pending
);

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd8;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd6;

	logic [PIX_W-1:0]      line_above     [MAX_WIDTH];
	logic [PIX_W-1:0]      line_two_above [MAX_WIDTH];
	logic [SIZE_W-1:0]     width_cfg;
	logic [SIZE_W-1:0]     height_cfg;
	logic [CFG_DATA_W-1:0] thr_cfg;
	logic [COUNT_W-1:0]    tally;
	int                    col;
	int                    row;
	logic [COUNT_W-1:0]    frame_counts_q [$];

	// A size of zero means one, and anything above the maximum size saturates.
	function automatic int clamp_dim(input logic [SIZE_W-1:0] v, input int lim);
		if (v == 0)
			return 1;
		if (int'(v) > lim)
			return lim;
		return int'(v);
	endfunction

	function automatic void restart_frame();
		col = 0;
		row = 0;
		tally = '0;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_FRAME_WIDTH:   width_cfg = data[SIZE_W-1:0];
			REG_FRAME_HEIGHT:  height_cfg = data[SIZE_W-1:0];
			REG_AVG_THRESHOLD: thr_cfg = data;
			default:           return;
		endcase
		restart_frame();
	endfunction

	// The centre one row up is judged when the pixel below it arrives.
	function automatic void tally_pixel(input logic [PIX_W-1:0] px);
		int w;
		int h;
		int sum;
		w = clamp_dim(width_cfg, MAX_WIDTH);
		h = clamp_dim(height_cfg, MAX_HEIGHT);
		if (col >= w)
			col = 0;
		if (row >= h)
			row = 0;
		if (row >= 2 && col >= 1 && col + 1 < w) begin
			sum = int'(line_above[col]) + int'(line_two_above[col]) + int'(px)
				+ int'(line_two_above[col-1]) + int'(line_above[col+1]);
			if (sum / 5 > int'(thr_cfg) && tally != COUNT_MAX)
				tally++;
		end
		line_two_above[col] = line_above[col];
		line_above[col] = px;
		if (col + 1 >= w) begin
			col = 0;
			if (row + 1 >= h) begin
				frame_counts_q.push_back(tally);
				restart_frame();
			end else begin
				row++;
			end
		end else begin
			col++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [COUNT_W-1:0] want;
		if (!arst_n) begin
			width_cfg = WIDTH_RESET;
			height_cfg = HEIGHT_RESET;
			thr_cfg = THRESHOLD_RESET;
			restart_frame();
			frame_counts_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_write)
				apply_reg(cfg_index, cfg_data);
			// Results are matched before this edge's pixel can add an expectation.
			if (out_valid && out_ready) begin
				if (frame_counts_q.size() == 0) begin
					errors++;
					$error("bright_count: no result expected, actual %0d", bright_count);
				end else begin
					want = frame_counts_q.pop_front();
					if (bright_count !== want) begin
						errors++;
						$error("bright_count mismatch: expected %0d, actual %0d",
							want, bright_count);
					end
				end
			end
			if (in_valid && in_ready)
				tally_pixel(pixel);
			pending = frame_counts_q.size();
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top of the cross stencil counter testbench: clock, reset, register writes,
// pixel frames, receiver stalls, the watchdog and the verdict.
// Depends on csbs_pkg, cross_stencil_bright_spot_counter_unit and csbs_count_checker.
module tb_top;
	import csbs_pkg::*;

	localparam int MAX_W          = 1024;
	localparam int MAX_H          = 1024;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS    = 180;

	typedef enum int {STYLE_FULL, STYLE_NEAR, STYLE_RAIL} pix_style_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [PIX_W-1:0]      pixel = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [COUNT_W-1:0]    bright_count;

	int errors;
	int pending;
	int send_idle = 0;
	int recv_idle = 0;
	int pushed = 0;
	int stall_cycles = 0;
	bit hold_req = 1'b0;
	int cur_w = 8;
	int cur_h = 6;
	int cur_t = 6;

	// A single bright centre whose cross sums to exactly 5*(6+1); corners are ignored.
	logic [PIX_W-1:0] cross_pix [9] = '{16'hFFFF, 16'd7, 16'hFFFF,
		16'd7, 16'd7, 16'd7, 16'hFFFF, 16'd7, 16'hFFFF};

	cross_stencil_bright_spot_counter_unit #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bright_count(bright_count)
	);

	csbs_count_checker #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bright_count(bright_count),
		.errors(errors),
		.pending(pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// A long hold-off is counted here so the sender can keep offering items meanwhile.
	initial begin : receiver
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic push_pixel(input logic [PIX_W-1:0] value);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pushed++;
		@(negedge clk);
	endtask

	// Let the block drain: no expectation left and the pipeline given time to empty.
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic program_regs(input bit wr_w, input bit wr_h, input bit wr_t,
			input logic [CFG_DATA_W-1:0] w_word, input logic [CFG_DATA_W-1:0] h_word,
			input logic [CFG_DATA_W-1:0] t_word);
		settle();
		if (wr_w)
			reg_write(REG_FRAME_WIDTH, w_word);
		if (wr_h)
			reg_write(REG_FRAME_HEIGHT, h_word);
		if (wr_t)
			reg_write(REG_AVG_THRESHOLD, t_word);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] make_pixel(input pix_style_t style, input int thr);
		int v;
		case (style)
			STYLE_NEAR: v = thr + 1 + int'($urandom_range(4)) - 2;
			STYLE_RAIL: v = $urandom_range(1) ? 65535 : 0;
			default:    v = int'($urandom_range(65535));
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return PIX_W'(v);
	endfunction

	task automatic feed_frame(input int n_pix, input pix_style_t style, input int thr);
		for (int i = 0; i < n_pix; i++)
			push_pixel(make_pixel(style, thr));
	endtask

	function automatic int pick_dim(input int mid_hi, input int wide_hi);
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return $urandom_range(1, 2);
		if (r < 80)
			return $urandom_range(3, mid_hi);
		return $urandom_range(mid_hi + 1, wide_hi);
	endfunction

	function automatic int pick_threshold();
		case ($urandom_range(9))
			0:       return 0;
			1:       return 65535;
			2:       return 65534;
			3, 4:    return $urandom_range(65535);
			default: return $urandom_range(40);
		endcase
	endfunction

	function automatic pix_style_t pick_style();
		int r;
		r = $urandom_range(9);
		if (r < 5)
			return STYLE_NEAR;
		if (r < 8)
			return STYLE_FULL;
		return STYLE_RAIL;
	endfunction

	// Size words sometimes carry junk above the register width, and one may be written as zero.
	function automatic logic [CFG_DATA_W-1:0] size_word(input int n);
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'(n);
		if (n == 1 && $urandom_range(1) == 1)
			word = '0;
		if ($urandom_range(7) == 0)
			word[CFG_DATA_W-1:SIZE_W] = (CFG_DATA_W - SIZE_W)'($urandom);
		return word;
	endfunction

	task automatic random_phase(input int budget);
		int start_cnt;
		int n_pix;
		int new_w;
		int new_h;
		int new_t;
		bit need_cfg;
		bit wr_w;
		bit wr_h;
		bit wr_t;
		start_cnt = pushed;
		need_cfg = 1'b1;
		while (pushed - start_cnt < budget) begin
			if (need_cfg || $urandom_range(2) == 0) begin
				{wr_w, wr_h, wr_t} = 3'($urandom_range(1, 7));
				new_w = wr_w ? pick_dim(12, 40) : cur_w;
				new_h = wr_h ? pick_dim(10, 20) : cur_h;
				new_t = wr_t ? pick_threshold() : cur_t;
				program_regs(wr_w, wr_h, wr_t, size_word(new_w), size_word(new_h),
					CFG_DATA_W'(new_t));
				cur_w = new_w;
				cur_h = new_h;
				cur_t = new_t;
			end
			need_cfg = 1'b0;
			n_pix = cur_w * cur_h;
			// Now and then a frame is cut short and restarted by a register write.
			if ($urandom_range(11) == 0) begin
				n_pix = $urandom_range(n_pix - 1);
				need_cfg = 1'b1;
			end
			feed_frame(n_pix, pick_style(), cur_t);
		end
	endtask

	initial begin : stimulus
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle = 19;
		recv_idle = 57;

		// A partial frame under the reset sizes, abandoned by the writes that follow.
		feed_frame(3, STYLE_FULL, cur_t);
		program_regs(1'b1, 1'b1, 1'b1, 16'd3, 16'd3, 16'hFFFE);
		cur_w = 3;
		cur_h = 3;
		cur_t = 65534;
		repeat (9) push_pixel(16'hFFFF);
		program_regs(1'b0, 1'b0, 1'b1, 16'd3, 16'd3, 16'd6);
		cur_t = 6;
		foreach (cross_pix[i])
			push_pixel(cross_pix[i]);
		// Zero sizes act as one: every pixel is a whole frame with no interior.
		program_regs(1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 16'd6);
		cur_w = 1;
		cur_h = 1;
		push_pixel(16'h0000);
		push_pixel(16'hFFFF);

		random_phase(PHASE_ITEMS);

		send_idle = 57;
		recv_idle = 19;
		random_phase(PHASE_ITEMS);

		send_idle = 0;
		recv_idle = 0;
		// One-pixel frames under a long receiver hold fill the block and stall its input.
		program_regs(1'b1, 1'b1, 1'b0, 16'd1, 16'd1, CFG_DATA_W'(cur_t));
		cur_w = 1;
		cur_h = 1;
		hold_req = 1'b1;
		feed_frame(40, STYLE_FULL, cur_t);
		settle();

		// An oversize width saturates at the store depth.
		cur_t = $urandom_range(65535);
		program_regs(1'b1, 1'b1, 1'b1, 16'hFFFF, 16'd1, CFG_DATA_W'(cur_t));
		cur_w = MAX_W;
		cur_h = 1;
		feed_frame(cur_w * cur_h, STYLE_NEAR, cur_t);
		// Back to a small frame so the next phase starts from modest sizes.
		program_regs(1'b1, 1'b1, 1'b0, 16'd8, 16'd6, CFG_DATA_W'(cur_t));
		cur_w = 8;
		cur_h = 6;

		random_phase(PHASE_ITEMS);

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/csbs_pkg.sv
rtl/csbs_raster_ctr.sv
rtl/csbs_line_store.sv
rtl/csbs_cross_cmp.sv
rtl/cross_stencil_bright_spot_counter_unit.sv
tb/csbs_count_checker.sv
tb/tb_top.sv
